/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Holds the table geometry, the action and status codes, and the probe
// record that walks the chain of block cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 64;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Fixed field widths at the ports.
    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 16;
    localparam int PID_W    = 6;
    localparam int EIDX_W   = 6;
    localparam int STATUS_W = 2;
    localparam int BIDX_W   = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOT_LOADED = 2'd3
    } status_t;

    // One item in flight. The request part travels unchanged; the result
    // part is filled in by the cell that serves the item, which also sets done.
    typedef struct packed {
        logic                 active;
        logic                 done;
        action_t              action;
        logic [SIZE_BITS-1:0] req_size;
        logic [PID_W-1:0]     pid;
        logic [EIDX_W-1:0]    eidx;
        logic [IDX_BITS-1:0]  res_idx;
        logic                 res_alloc;
        logic [PID_W-1:0]     res_owner;
        logic [SIZE_BITS-1:0] res_cap;
        logic [SIZE_BITS-1:0] res_held;
    } probe_t;

    // Occupancy flags of one cell.
    typedef struct packed {
        logic loaded;
        logic allocated;
    } cell_status_t;

endpackage

/* hw/rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator: table of fixed memory blocks, first-fit placement
// A row of block cells that each item walks from the lowest index upward.
// ----------------------------------------------------------------------------
// Every accepted item enters cell 0 and, while the row is not stalled, moves
// cell by cell along a row of NUM_BLOCKS cells and then into the output
// register, which holds its result item. Items follow each other through the
// row, so a new item can be accepted in every cycle in which the output
// register is empty or being taken, and results come out in acceptance order.
// Because an earlier item always reaches a cell before a later one, each item
// sees the table exactly as every earlier item left it. A load item is stored
// by the first cell that holds no block; an allocate item is claimed by the
// first loaded, free cell whose size is large enough, which is the first fit;
// a read item is answered by the cell whose index it names. An item that
// leaves the row unserved reports table full, no fit or index not loaded
// according to its action. A stall on the result side freezes the whole row
// and holds off new items. Reset clears the loaded and allocated flags of
// every cell at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [ffba_pkg::ACTION_W-1:0] action,
    input  logic [ffba_pkg::SIZE_W-1:0]   size_value,
    input  logic [ffba_pkg::PID_W-1:0]    process_id,
    input  logic [ffba_pkg::EIDX_W-1:0]   entry_index,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    output logic [ffba_pkg::BIDX_W-1:0]   block_index,
    output logic                          is_allocated,
    output logic [ffba_pkg::PID_W-1:0]    owner_id,
    output logic [ffba_pkg::SIZE_W-1:0]   block_capacity,
    output logic [ffba_pkg::SIZE_W-1:0]   held_size,
    output logic [ffba_pkg::SIZE_W-1:0]   fragment
);

    ffba_pkg::probe_t               chain_probe [ffba_pkg::NUM_BLOCKS+1];
    ffba_pkg::cell_status_t         cell_stat   [ffba_pkg::NUM_BLOCKS];
    logic [ffba_pkg::NUM_BLOCKS-1:0] loaded_vec;
    logic [ffba_pkg::NUM_BLOCKS-1:0] alloc_vec;
    logic                           advance;
    ffba_pkg::probe_t               head_probe;
    ffba_pkg::probe_t               tail;

    logic                           result_valid_reg;
    logic [ffba_pkg::STATUS_W-1:0]  status_reg;
    logic [ffba_pkg::STATUS_W-1:0]  status_next;
    logic [ffba_pkg::BIDX_W-1:0]    block_index_reg;
    logic [ffba_pkg::BIDX_W-1:0]    block_index_next;
    logic                           is_allocated_reg;
    logic                           is_allocated_next;
    logic [ffba_pkg::PID_W-1:0]     owner_id_reg;
    logic [ffba_pkg::PID_W-1:0]     owner_id_next;
    logic [ffba_pkg::SIZE_W-1:0]    capacity_reg;
    logic [ffba_pkg::SIZE_W-1:0]    capacity_next;
    logic [ffba_pkg::SIZE_W-1:0]    held_reg;
    logic [ffba_pkg::SIZE_W-1:0]    held_next;
    logic [ffba_pkg::SIZE_W-1:0]    fragment_reg;
    logic [ffba_pkg::SIZE_W-1:0]    fragment_next;

    // The whole row moves only when the output register can take the item
    // leaving the last cell.
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    // New item entering cell 0; a bubble when nothing is offered.
    always_comb
    begin
        head_probe           = '0;
        head_probe.active    = item_valid;
        head_probe.done      = 1'b0;
        head_probe.action    = ffba_pkg::action_t'(action);
        head_probe.req_size  = ffba_pkg::SIZE_BITS'(size_value);
        head_probe.pid       = process_id;
        head_probe.eidx      = entry_index;
    end

    assign chain_probe[0] = head_probe;

    for (genvar i = 0; i < ffba_pkg::NUM_BLOCKS; i++)
    begin : g_cell
        ffba_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .cell_id     (ffba_pkg::IDX_BITS'(i)),
            .probe_in    (chain_probe[i]),
            .probe_out   (chain_probe[i+1]),
            .cell_status (cell_stat[i])
        );
        assign loaded_vec[i] = cell_stat[i].loaded;
        assign alloc_vec[i]  = cell_stat[i].allocated;
    end

    assign tail = chain_probe[ffba_pkg::NUM_BLOCKS];

    // Turn the item leaving the row into a result. An unserved item reports
    // why nothing matched and zeros in every other field.
    always_comb
    begin
        status_next       = ffba_pkg::ST_OK;
        block_index_next  = ffba_pkg::BIDX_W'(tail.res_idx);
        is_allocated_next = tail.res_alloc;
        owner_id_next     = tail.res_owner;
        capacity_next     = ffba_pkg::SIZE_W'(tail.res_cap);
        held_next         = ffba_pkg::SIZE_W'(tail.res_held);
        fragment_next     = ffba_pkg::SIZE_W'(ffba_pkg::SIZE_BITS'(tail.res_cap -
                                                                   tail.res_held));
        if (!tail.done)
        begin
            unique case (tail.action)
                ffba_pkg::ACT_LOAD:  status_next = ffba_pkg::ST_FULL;
                ffba_pkg::ACT_ALLOC: status_next = ffba_pkg::ST_NO_FIT;
                default:             status_next = ffba_pkg::ST_NOT_LOADED;
            endcase
            block_index_next  = '0;
            is_allocated_next = 1'b0;
            owner_id_next     = '0;
            capacity_next     = '0;
            held_next         = '0;
            fragment_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= tail.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg       <= status_next;
            block_index_reg  <= block_index_next;
            is_allocated_reg <= is_allocated_next;
            owner_id_reg     <= owner_id_next;
            capacity_reg     <= capacity_next;
            held_reg         <= held_next;
            fragment_reg     <= fragment_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign block_index    = block_index_reg;
    assign is_allocated   = is_allocated_reg;
    assign owner_id       = owner_id_reg;
    assign block_capacity = capacity_reg;
    assign held_size      = held_reg;
    assign fragment       = fragment_reg;

    // Loaded blocks always form a contiguous run starting at block 0.
    a_loaded_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (loaded_vec & (loaded_vec + 1'b1)) == '0)
        else $error("loaded blocks are not a contiguous run from block 0");

    // Only a loaded block can hold a process.
    a_alloc_in_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_vec & ~loaded_vec) == '0)
        else $error("allocated flag set on a block that is not loaded");

    // While the result side stalls, the item in the last cell stays put.
    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> $stable(tail))
        else $error("item left the last cell during an output stall");

endmodule

/* hw/rtl/ffba_cell.sv */
// ----------------------------------------------------------------------------
// ffba_cell: one block of the allocator table
// Holds one block entry and one stage of the probe chain. An item that no
// earlier cell has served is served here when this entry matches it.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [ffba_pkg::IDX_BITS-1:0]  cell_id,
    input  ffba_pkg::probe_t               probe_in,
    output ffba_pkg::probe_t               probe_out,
    output ffba_pkg::cell_status_t         cell_status
);

    ffba_pkg::probe_t                    probe_reg;
    ffba_pkg::probe_t                    probe_next;
    logic                                loaded_reg;
    logic                                loaded_next;
    logic                                alloc_reg;
    logic                                alloc_next;
    logic [ffba_pkg::SIZE_BITS-1:0]      size_reg;
    logic [ffba_pkg::SIZE_BITS-1:0]      size_next;
    logic [ffba_pkg::PID_W-1:0]          owner_reg;
    logic [ffba_pkg::PID_W-1:0]          owner_next;
    logic [ffba_pkg::SIZE_BITS-1:0]      held_reg;
    logic [ffba_pkg::SIZE_BITS-1:0]      held_next;
    logic                                id_match;

    // Compare at a width that holds both the requested and the local index.
    assign id_match = ((ffba_pkg::EIDX_W + ffba_pkg::IDX_BITS)'(probe_in.eidx) ==
                       (ffba_pkg::EIDX_W + ffba_pkg::IDX_BITS)'(cell_id));

    always_comb
    begin
        probe_next  = probe_in;
        loaded_next = loaded_reg;
        alloc_next  = alloc_reg;
        size_next   = size_reg;
        owner_next  = owner_reg;
        held_next   = held_reg;
        if (probe_in.active && !probe_in.done)
        begin
            unique case (probe_in.action)
                ffba_pkg::ACT_LOAD:
                begin
                    if (!loaded_reg)
                    begin
                        loaded_next          = 1'b1;
                        alloc_next           = 1'b0;
                        size_next            = probe_in.req_size;
                        probe_next.done      = 1'b1;
                        probe_next.res_idx   = cell_id;
                        probe_next.res_alloc = 1'b0;
                        probe_next.res_owner = '0;
                        probe_next.res_cap   = probe_in.req_size;
                        probe_next.res_held  = '0;
                    end
                end
                ffba_pkg::ACT_ALLOC:
                begin
                    if (loaded_reg && !alloc_reg && (size_reg >= probe_in.req_size))
                    begin
                        alloc_next           = 1'b1;
                        owner_next           = probe_in.pid;
                        held_next            = probe_in.req_size;
                        probe_next.done      = 1'b1;
                        probe_next.res_idx   = cell_id;
                        probe_next.res_alloc = 1'b1;
                        probe_next.res_owner = probe_in.pid;
                        probe_next.res_cap   = size_reg;
                        probe_next.res_held  = probe_in.req_size;
                    end
                end
                ffba_pkg::ACT_READ:
                begin
                    if (loaded_reg && id_match)
                    begin
                        probe_next.done      = 1'b1;
                        probe_next.res_idx   = cell_id;
                        probe_next.res_alloc = alloc_reg;
                        probe_next.res_owner = alloc_reg ? owner_reg : '0;
                        probe_next.res_cap   = size_reg;
                        probe_next.res_held  = alloc_reg ? held_reg : '0;
                    end
                end
                default:
                begin
                    probe_next = probe_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg  <= '0;
            loaded_reg <= 1'b0;
            alloc_reg  <= 1'b0;
        end
        else if (advance)
        begin
            probe_reg  <= probe_next;
            loaded_reg <= loaded_next;
            alloc_reg  <= alloc_next;
        end
    end

    // Entry payload is only read once the matching flag says it is valid.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            size_reg  <= size_next;
            owner_reg <= owner_next;
            held_reg  <= held_next;
        end
    end

    assign probe_out             = probe_reg;
    assign cell_status.loaded    = loaded_reg;
    assign cell_status.allocated = alloc_reg;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-fit block allocator
// Drives load, allocate and read items through the valid/stall handshake,
// predicts every result item from its own copy of the block table and checks
// each field of each result in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    // The package names only the three real actions; the fourth code is
    // unused by the block and must answer with index not loaded.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    // Number of random items after the directed opening.
    localparam int RANDOM_ITEMS = 1530;

    // An item passes through every block cell and then the output register;
    // the tail wait after the last result covers that passage and a margin.
    localparam int TAIL_CYCLES = NUM_BLOCKS + 16;

    // One result item as the block reports it. Status is kept as a raw vector
    // so that an unknown value on the port is caught by the compare.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIDX_W-1:0]   idx;
        logic                alloc;
        logic [PID_W-1:0]    owner;
        logic [SIZE_W-1:0]   cap;
        logic [SIZE_W-1:0]   held;
        logic [SIZE_W-1:0]   frag;
    } block_report_t;

    // The scoreboard owns a private copy of the block table. Each accepted
    // item is played against that copy right away, which is sound because
    // the block serves items strictly in acceptance order, and the predicted
    // result is queued until the matching result item comes out.
    class alloc_scoreboard;
        logic [SIZE_BITS-1:0] cap [NUM_BLOCKS];
        bit                   taken [NUM_BLOCKS];
        logic [PID_W-1:0]     owner [NUM_BLOCKS];
        logic [SIZE_BITS-1:0] held [NUM_BLOCKS];
        int unsigned          loaded;
        block_report_t        awaited_q [$];
        int unsigned          results_seen;
        int unsigned          errors;

        function new();
            loaded       = 0;
            results_seen = 0;
            errors       = 0;
            foreach (taken[i])
            begin
                taken[i] = 1'b0;
            end
        endfunction

        // Status of one loaded entry, as load, allocate and read report it.
        function block_report_t entry_status(int unsigned i);
            block_report_t r;
            r        = '0;
            r.status = ST_OK;
            r.idx    = BIDX_W'(i);
            r.cap    = SIZE_W'(cap[i]);
            if (taken[i])
            begin
                r.alloc = 1'b1;
                r.owner = owner[i];
                r.held  = SIZE_W'(held[i]);
                r.frag  = SIZE_W'(SIZE_BITS'(cap[i] - held[i]));
            end
            else
            begin
                r.frag = SIZE_W'(cap[i]);
            end
            return r;
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [SIZE_W-1:0] size,
                                logic [PID_W-1:0] pid, logic [EIDX_W-1:0] eidx);
            block_report_t r;
            int unsigned   j;
            bit            placed;
            r      = '0;
            placed = 1'b0;
            case (act)
                ACT_LOAD:
                begin
                    if (loaded >= NUM_BLOCKS)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        cap[loaded]   = SIZE_BITS'(size);
                        taken[loaded] = 1'b0;
                        owner[loaded] = '0;
                        held[loaded]  = '0;
                        r             = entry_status(loaded);
                        loaded++;
                    end
                end
                ACT_ALLOC:
                begin
                    for (j = 0; j < loaded && !placed; j++)
                    begin
                        if (!taken[j] && cap[j] >= SIZE_BITS'(size))
                        begin
                            taken[j] = 1'b1;
                            owner[j] = pid;
                            held[j]  = SIZE_BITS'(size);
                            r        = entry_status(j);
                            placed   = 1'b1;
                        end
                    end
                    if (!placed)
                    begin
                        r.status = ST_NO_FIT;
                    end
                end
                ACT_READ:
                begin
                    if (eidx < loaded)
                    begin
                        r = entry_status(32'(eidx));
                    end
                    else
                    begin
                        r.status = ST_NOT_LOADED;
                    end
                end
                default:
                begin
                    r.status = ST_NOT_LOADED;
                end
            endcase
            awaited_q.push_back(r);
        endfunction

        function int unsigned outstanding();
            return awaited_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
            end
        endtask

        task check_result(block_report_t got);
            block_report_t want;
            if (awaited_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with no item outstanding (status %0h)",
                                 results_seen, got.status));
            end
            else
            begin
                want = awaited_q.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("block_index", 32'(got.idx), 32'(want.idx));
                compare_field("is_allocated", 32'(got.alloc), 32'(want.alloc));
                compare_field("owner_id", 32'(got.owner), 32'(want.owner));
                compare_field("block_capacity", 32'(got.cap), 32'(want.cap));
                compare_field("held_size", 32'(got.held), 32'(want.held));
                compare_field("fragment", 32'(got.frag), 32'(want.frag));
            end
            results_seen++;
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [ACTION_W-1:0] action;
    logic [SIZE_W-1:0]   size_value;
    logic [PID_W-1:0]    process_id;
    logic [EIDX_W-1:0]   entry_index;
    logic                result_valid;
    logic                result_stall;
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   block_index;
    logic                is_allocated;
    logic [PID_W-1:0]    owner_id;
    logic [SIZE_W-1:0]   block_capacity;
    logic [SIZE_W-1:0]   held_size;
    logic [SIZE_W-1:0]   fragment;

    alloc_scoreboard sb;

    // Each side now and then switches into a steady stretch with no idling
    // at all, so that back-to-back traffic is covered as well as gaps.
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    first_fit_block_allocator uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sends one item. The task is entered at a rising edge and returns at the
    // edge where the item was accepted, so the next call can keep valid high
    // for back-to-back items without ever lowering it in the same step.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [SIZE_W-1:0] size,
                             logic [PID_W-1:0] pid, logic [EIDX_W-1:0] eidx);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        action      <= act;
        size_value  <= size;
        process_id  <= pid;
        entry_index <= eidx;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        sb.note_item(act, size, pid, eidx);
    endtask

    // Result side. For every result item it draws a number of cycles to hold
    // stall high, then takes the next result that shows up. Stall is only
    // raised at the edge of an accept or while no result is being taken, so
    // the sampled values at each edge are the ones the block saw.
    initial
    begin
        int unsigned hold;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                take_steady = !take_steady;
            end
            hold = take_steady ? 0 : $urandom_range(0, 12);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            sb.check_result('{status, block_index, is_allocated, owner_id,
                              block_capacity, held_size, fragment});
        end
    end

    // Main stimulus: a directed opening, then a long random stream.
    initial
    begin
        int unsigned         n;
        int unsigned         pick;
        int unsigned         start;
        int unsigned         k;
        int unsigned         slot;
        bit                  found;
        logic [ACTION_W-1:0] act;
        logic [SIZE_W-1:0]   size;
        logic [PID_W-1:0]    pid;
        logic [EIDX_W-1:0]   eidx;

        sb = new();
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        action      <= ACT_LOAD;
        size_value  <= '0;
        process_id  <= '0;
        entry_index <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests against an empty table: a read finds nothing loaded, an
        // allocate finds no fit, and the unused action code is answered as
        // index not loaded.
        send_item(ACT_READ, 16'h0000, 6'd0, 6'd0);
        send_item(ACT_ALLOC, 16'h0000, 6'd5, 6'd0);
        send_item(ACT_SPARE, 16'hFFFF, 6'd63, 6'd63);

        // A handful of blocks that span the size range, both extremes among
        // them.
        send_item(ACT_LOAD, 16'h0000, 6'd63, 6'd63);
        send_item(ACT_LOAD, 16'hFFFF, 6'd0, 6'd0);
        send_item(ACT_LOAD, 16'h0001, 6'd0, 6'd0);
        send_item(ACT_LOAD, 16'h8000, 6'd0, 6'd0);
        send_item(ACT_LOAD, 16'h7FFF, 6'd0, 6'd0);

        // A zero request takes the zero-sized block 0. The full-size request
        // then fits block 1 exactly and leaves no fragment; a second one no
        // longer fits. A request of two skips the one-unit block 2 and lands
        // in block 3. Exact-size and one-too-large requests probe the compare.
        send_item(ACT_ALLOC, 16'h0000, 6'd63, 6'd0);
        send_item(ACT_ALLOC, 16'hFFFF, 6'd0, 6'd63);
        send_item(ACT_ALLOC, 16'hFFFF, 6'd1, 6'd0);
        send_item(ACT_ALLOC, 16'h0002, 6'd42, 6'd21);
        send_item(ACT_ALLOC, 16'h8000, 6'd7, 6'd0);
        send_item(ACT_ALLOC, 16'h7FFF, 6'd21, 6'd42);
        send_item(ACT_ALLOC, 16'h0001, 6'd33, 6'd0);

        // Read every loaded entry back, then two indexes past the end.
        for (n = 0; n < 5; n++)
        begin
            send_item(ACT_READ, 16'hFFFF, 6'd63, EIDX_W'(n));
        end
        send_item(ACT_READ, 16'h0000, 6'd0, 6'd5);
        send_item(ACT_READ, 16'hFFFF, 6'd63, 6'd63);

        // Random stream. Loads are frequent until the table is full and rare
        // after that, so the table-full answer is seen many times. Allocate
        // requests mix random sizes, near-full-range sizes, zero, and sizes
        // taken from a free block (exact or one above) to hit the boundary
        // of the first-fit compare. Fields an action ignores stay random.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            size = SIZE_W'($urandom_range(0, 65535));
            pid  = PID_W'($urandom_range(0, 63));
            eidx = EIDX_W'($urandom_range(0, 63));
            pick = $urandom_range(0, 99);
            if (pick < ((sb.loaded >= NUM_BLOCKS) ? 4 : 22))
            begin
                act = ACT_LOAD;
                case ($urandom_range(0, 3))
                    0: size = SIZE_W'($urandom_range(0, 255));
                    1: size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: ;
                endcase
            end
            else if (pick < 45)
            begin
                act = ACT_ALLOC;
                case ($urandom_range(0, 9))
                    0: size = '0;
                    1, 2: size = SIZE_W'($urandom_range(16'hF000, 16'hFFFF));
                    3, 4, 5:
                    begin
                        start = $urandom_range(0, NUM_BLOCKS - 1);
                        found = 1'b0;
                        for (k = 0; k < NUM_BLOCKS && !found; k++)
                        begin
                            slot = (start + k) % NUM_BLOCKS;
                            if (slot < sb.loaded && !sb.taken[slot])
                            begin
                                size  = SIZE_W'(sb.cap[slot]) +
                                        SIZE_W'($urandom_range(0, 1));
                                found = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            else if (pick < 95)
            begin
                act = ACT_READ;
            end
            else
            begin
                act = ACT_SPARE;
            end
            send_item(act, size, pid, eidx);
        end
        item_valid <= 1'b0;

        // Wait for every predicted result, then give the row time to push out
        // anything extra before deciding.
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog. A correct run needs well under a tenth of this time even
    // with both sides idling as long as they may on every item.
    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
